[sv/lpfr_pkg.sv]
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and codes for the length-prefixed frame receiver: parser
// phases, result kinds, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

  // configuration port
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CfgIndexW-1:0] REG_HEADER_VALUE = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_FOOTER_VALUE = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_GOOD_END = 2'd1;
  localparam logic [1:0] KIND_BAD_END  = 2'd2;

  // parser phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_FOOTER  = 3'd4
  } lpfr_phase_t;

  // one result record from the parser
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic        last;
  } lpfr_result_t;

endpackage

`default_nettype wire

[sv/lpfr_parser.sv]
// ----------------------------------------------------------------------------
// lpfr_parser
// Frame parser state machine: hunts for the header, gathers the
// little-endian length, numbers payload bytes and checks the footer.
// One byte is consumed in each cycle that step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_parser
  import lpfr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [7:0]   header_value,
  input  wire logic [7:0]   footer_value,
  output lpfr_result_t      result
);

  lpfr_phase_t  phase;
  lpfr_phase_t  phase_next;
  logic [7:0]   length_low_byte;
  logic [15:0]  frame_length;
  logic [15:0]  bytes_seen;
  logic [15:0]  new_length;
  logic         is_last;

  // length assembled from the high byte now arriving
  assign new_length = {rx_byte, length_low_byte};

  // final payload byte of the frame
  assign is_last = (({1'b0, bytes_seen} + 17'd1) == {1'b0, frame_length});

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == header_value) begin
          phase_next = PH_LEN_LO;
        end
      end
      PH_LEN_LO:  phase_next = PH_LEN_HI;
      PH_LEN_HI: begin
        phase_next = (new_length == 16'd0) ? PH_FOOTER : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (is_last) begin
          phase_next = PH_FOOTER;
        end
      end
      PH_FOOTER:  phase_next = PH_HUNT;
      default:    phase_next = PH_HUNT;
    endcase
  end

  // result for the byte being consumed
  always_comb begin
    result       = '0;
    result.data  = rx_byte;
    case (phase)
      PH_PAYLOAD: begin
        result.valid = step;
        result.kind  = KIND_DATA;
        result.index = bytes_seen;
        result.last  = is_last;
      end
      PH_FOOTER: begin
        result.valid = step;
        result.kind  = (rx_byte == footer_value) ? KIND_GOOD_END : KIND_BAD_END;
        result.index = frame_length;
      end
      default: begin
        result.valid = 1'b0;
      end
    endcase
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // length and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      length_low_byte <= '0;
      frame_length    <= '0;
      bytes_seen      <= '0;
    end else if (step) begin
      case (phase)
        PH_LEN_LO: begin
          length_low_byte <= rx_byte;
        end
        PH_LEN_HI: begin
          frame_length <= new_length;
          bytes_seen   <= '0;
        end
        PH_PAYLOAD: begin
          bytes_seen <= bytes_seen + 16'd1;
        end
        default: begin
          bytes_seen <= bytes_seen;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/length_prefixed_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_top
// Receives serial bytes, finds header-framed packets with a 16-bit
// little-endian length, passes payload bytes on and reports the footer check.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | in_valid/in_ready  | rx_byte
//  output  | out_valid/out_ready| out_kind, out_byte, out_index, out_last
//  config  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One byte per cycle sustained while the output is not stalled; a byte's result
//  is loaded into the output register after its transaction (input register, then parser).
//  Bytes that give no result (hunt, header, length) are consumed silently.
//  rst is synchronous: parser returns to the hunt, both registers read zero.
//  A stalled output holds the parser; the input register takes one more byte.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_receiver_top
  import lpfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input bytes
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           rx_byte,
  // results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_byte,
  output logic [15:0]               out_index,
  output logic                      out_last,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  logic         byte_valid;
  logic [7:0]   byte_reg;
  logic         advance;
  logic [7:0]   header_value;
  logic [7:0]   footer_value;
  lpfr_result_t result;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= '0;
      footer_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_VALUE: header_value <= cfg_data;
        REG_FOOTER_VALUE: footer_value <= cfg_data;
        default: begin
          header_value <= header_value;
        end
      endcase
    end
  end

  // parser consumes the held byte when the result register is free
  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= rx_byte;
    end
  end

  lpfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .rx_byte      (byte_reg),
    .header_value (header_value),
    .footer_value (footer_value),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid && (!out_valid || out_ready)) begin
      out_kind  <= result.kind;
      out_byte  <= result.data;
      out_index <= result.index;
      out_last  <= result.last;
    end
  end

endmodule

`default_nettype wire
